>>> hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the block cache tag logic.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, disabled while reset is asserted.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);

// Clocked implication checked on the following edge.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/fbct_pkg.sv
// ----------------------------------------------------------------------------
// fbct_pkg
// Types and constants shared by the block cache tag cells and controller.
// ----------------------------------------------------------------------------
package fbct_pkg;

  localparam int SLOT_W = 4;
  localparam int CMD_W  = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_LOOKUP = 2'd0,
    CMD_ALLOC  = 2'd1,
    CMD_MARK   = 2'd2,
    CMD_FLUSH  = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_EXEC = 3'b010,
    ST_SCAN = 3'b100
  } state_t;

  // broadcast controls from the controller to every cell
  typedef struct packed {
    logic cmp;         // compare key, register match
    logic alloc;       // write key at pointer cell, rotate pointer
    logic mark;        // set dirty in the matching cell
    logic clear;       // drop all entries, pointer back to cell 0
    logic scan_start;  // snapshot dirty entries, scan token to cell 0
    logic scan_step;   // move scan token one cell on
  } cell_ctl_t;

  // per-cell status back to the controller
  typedef struct packed {
    logic valid;
    logic match;
    logic vd;    // valid and dirty
    logic ptr;   // insert pointer token
    logic scan;  // flush scan token
    logic pend;  // dirty entry not yet written back by the flush
  } cell_stat_t;

endpackage

>>> hw/rtl/fbct_cell.sv
// ----------------------------------------------------------------------------
// fbct_cell
// One cache entry: tag, valid, dirty, plus its share of the insert pointer
// and flush scan tokens, which shift cell to cell.
// ----------------------------------------------------------------------------
module fbct_cell #(
  parameter int BLOCK_NUM_BITS = 24,
  parameter bit HEAD           = 1'b0
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  fbct_pkg::cell_ctl_t       ctl,
  input  logic [BLOCK_NUM_BITS-1:0] key,
  input  logic                      ptr_in,
  input  logic                      scan_in,
  output fbct_pkg::cell_stat_t      stat,
  output logic [BLOCK_NUM_BITS-1:0] tag
);
  import fbct_pkg::*;

  logic [BLOCK_NUM_BITS-1:0] tag_r;
  logic                      valid_r;
  logic                      dirty_r;
  logic                      match_r;
  logic                      ptr_r;
  logic                      scan_r;
  logic                      pend_r;

  // tag has no reset: only read while valid
  always_ff @(posedge clk) begin
    if (ctl.alloc && ptr_r) begin
      tag_r <= key;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      dirty_r <= 1'b0;
      match_r <= 1'b0;
      ptr_r   <= HEAD;
      scan_r  <= 1'b0;
      pend_r  <= 1'b0;
    end else begin
      if (ctl.cmp) begin
        match_r <= valid_r && (tag_r == key);
      end
      if (ctl.clear) begin
        valid_r <= 1'b0;
        dirty_r <= 1'b0;
        ptr_r   <= HEAD;
      end else if (ctl.alloc) begin
        if (ptr_r) begin
          valid_r <= 1'b1;
          dirty_r <= 1'b0;
        end
        ptr_r <= ptr_in;
      end else if (ctl.mark && match_r) begin
        dirty_r <= 1'b1;
      end
      if (ctl.scan_start) begin
        scan_r <= HEAD;
        pend_r <= valid_r && dirty_r;
      end else if (ctl.scan_step) begin
        scan_r <= scan_in;
        pend_r <= pend_r && !scan_r;
      end
    end
  end

  assign stat.valid = valid_r;
  assign stat.match = match_r;
  assign stat.vd    = valid_r && dirty_r;
  assign stat.ptr   = ptr_r;
  assign stat.scan  = scan_r;
  assign stat.pend  = pend_r;
  assign tag        = tag_r;

endmodule

>>> hw/rtl/fifo_block_cache_tags.sv
// ----------------------------------------------------------------------------
// fifo_block_cache_tags
// Tag and policy logic of a fully associative write-back block cache with
// ring (FIFO) replacement, built as a row of entry cells.
// ----------------------------------------------------------------------------
//
// Channel  Dir  Group                         Content
// in_      in   tvalid/tready/tdata/tuser     one command and its block number
// out_     out  tvalid/tready/tdata/tlast     one result, tlast on the final one
//
// Lookup, allocate and mark dirty compare the key in every cell at once in the transfer
// cycle; EXEC then resolves the registered match and loads the output register once it
// is free. Flush snapshots the dirty entries and walks a scan token along the row up to
// the last one, one write-back each. Reset (rst_n low, synchronous) empties the table and
// parks the insert pointer at cell 0. A stalled output holds the controller; a new command
// is taken once it is idle, even while the last result waits in the output reg.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module fifo_block_cache_tags #(
  parameter int ENTRIES        = 16,
  parameter int BLOCK_NUM_BITS = 24
) (
  input  logic clk,
  input  logic rst_n,

  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  // block_num
  input  logic [((BLOCK_NUM_BITS+7)/8)*8-1:0]   in_tdata,
  // cmd
  input  logic [fbct_pkg::CMD_W-1:0]            in_tuser,

  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  // hit, slot, writeback, writeback_block, writeback_slot
  output logic [((BLOCK_NUM_BITS+17)/8)*8-1:0]  out_tdata,
  output logic                                  out_tlast
);
  import fbct_pkg::*;

  localparam int OUT_W = ((BLOCK_NUM_BITS + 17) / 8) * 8;

  // --------------------------------------------------------------------------
  // controller state
  // --------------------------------------------------------------------------
  state_t                    state_r, state_nxt;
  cmd_t                      cmd_r;
  logic [BLOCK_NUM_BITS-1:0] key_r;
  logic                      emitted_r, emitted_nxt;

  // output register
  logic                      out_valid_r;
  logic                      o_hit_r, o_wb_r, o_last_r;
  logic [SLOT_W-1:0]         o_slot_r, o_wb_slot_r;
  logic [BLOCK_NUM_BITS-1:0] o_wb_block_r;

  logic                      load;
  logic                      n_hit, n_wb, n_last;
  logic [SLOT_W-1:0]         n_slot, n_wb_slot;
  logic [BLOCK_NUM_BITS-1:0] n_wb_block;

  logic                      in_xfer;
  logic                      out_free;
  logic [BLOCK_NUM_BITS-1:0] in_block;
  cmd_t                      in_cmd;

  // --------------------------------------------------------------------------
  // cell row
  // --------------------------------------------------------------------------
  cell_ctl_t                 cell_ctl;
  logic [BLOCK_NUM_BITS-1:0] cell_key;
  cell_stat_t                cell_stat [ENTRIES];
  logic [BLOCK_NUM_BITS-1:0] tag_q     [ENTRIES];
  logic [ENTRIES-1:0]        valid_vec, match_vec, vd_vec, ptr_vec, scan_vec, pend_vec;

  assign in_block = in_tdata[BLOCK_NUM_BITS-1:0];
  assign in_cmd   = cmd_t'(in_tuser);
  assign in_tready = (state_r == ST_IDLE);
  assign in_xfer  = in_tvalid && in_tready;
  assign out_free = !out_valid_r || out_tready;

  // compare uses the incoming key during the transfer, the held key later
  assign cell_key = (state_r == ST_IDLE) ? in_block : key_r;

  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    localparam int PREV = (g == 0) ? ENTRIES - 1 : g - 1;
    logic scan_in;

    // pointer token rotates around the ring; scan token enters nowhere
    assign scan_in = (g == 0) ? 1'b0 : scan_vec[PREV];

    fbct_cell #(
      .BLOCK_NUM_BITS (BLOCK_NUM_BITS),
      .HEAD           (g == 0)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .ctl     (cell_ctl),
      .key     (cell_key),
      .ptr_in  (ptr_vec[PREV]),
      .scan_in (scan_in),
      .stat    (cell_stat[g]),
      .tag     (tag_q[g])
    );

    assign valid_vec[g] = cell_stat[g].valid;
    assign match_vec[g] = cell_stat[g].match;
    assign vd_vec[g]    = cell_stat[g].vd;
    assign ptr_vec[g]   = cell_stat[g].ptr;
    assign scan_vec[g]  = cell_stat[g].scan;
    assign pend_vec[g]  = cell_stat[g].pend;
  end

  // --------------------------------------------------------------------------
  // selection over the row: at most one cell is hot in each of the
  // match, pointer and scan vectors, so a plain and-or picks its fields
  // --------------------------------------------------------------------------
  logic                      hit_any;
  logic [SLOT_W-1:0]         hit_slot;
  logic                      vic_wb;
  logic [SLOT_W-1:0]         vic_slot;
  logic [BLOCK_NUM_BITS-1:0] vic_tag;
  logic                      scan_emit;
  logic [SLOT_W-1:0]         scan_slot;
  logic [BLOCK_NUM_BITS-1:0] scan_tag;
  logic                      rem_any;

  always_comb begin
    hit_slot  = '0;
    vic_slot  = '0;
    vic_tag   = '0;
    scan_slot = '0;
    scan_tag  = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (match_vec[i]) begin
        hit_slot = hit_slot | SLOT_W'(i);
      end
      if (ptr_vec[i]) begin
        vic_slot = vic_slot | SLOT_W'(i);
      end
      if (ptr_vec[i] && vd_vec[i]) begin
        vic_tag = vic_tag | tag_q[i];
      end
      if (scan_vec[i] && pend_vec[i]) begin
        scan_slot = scan_slot | SLOT_W'(i);
        scan_tag  = scan_tag | tag_q[i];
      end
    end
  end

  assign hit_any   = |match_vec;
  assign vic_wb    = |(ptr_vec & vd_vec);
  assign scan_emit = |(scan_vec & pend_vec);
  // dirty entries still waiting after the current scan position
  assign rem_any   = |(pend_vec & ~scan_vec);

  // --------------------------------------------------------------------------
  // sequencer
  // --------------------------------------------------------------------------
  logic scan_go;
  logic scan_need;

  always_comb begin
    state_nxt   = state_r;
    emitted_nxt = emitted_r;
    cell_ctl    = '0;
    load        = 1'b0;
    n_hit       = 1'b0;
    n_slot      = '0;
    n_wb        = 1'b0;
    n_wb_block  = '0;
    n_wb_slot   = '0;
    n_last      = 1'b1;
    scan_need   = scan_emit || (!rem_any && !emitted_r);
    scan_go     = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          if (in_cmd == CMD_FLUSH) begin
            cell_ctl.scan_start = 1'b1;
            emitted_nxt         = 1'b0;
            state_nxt           = ST_SCAN;
          end else begin
            cell_ctl.cmp = 1'b1;
            state_nxt    = ST_EXEC;
          end
        end
      end

      ST_EXEC: begin
        if (out_free) begin
          load      = 1'b1;
          state_nxt = ST_IDLE;
          if (hit_any || cmd_r != CMD_ALLOC) begin
            n_hit         = hit_any;
            n_slot        = hit_slot;
            cell_ctl.mark = (cmd_r == CMD_MARK);
          end else begin
            // miss on allocate: replace the entry under the ring pointer
            cell_ctl.alloc = 1'b1;
            n_slot         = vic_slot;
            n_wb           = vic_wb;
            n_wb_block     = vic_tag;
            n_wb_slot      = vic_wb ? vic_slot : '0;
          end
        end
      end

      ST_SCAN: begin
        scan_go = !scan_need || out_free;
        if (scan_go) begin
          cell_ctl.scan_step = 1'b1;
          load               = scan_need;
          n_wb               = scan_emit;
          n_wb_block         = scan_tag;
          n_wb_slot          = scan_slot;
          n_last             = !rem_any;
          if (scan_emit) begin
            emitted_nxt = 1'b1;
          end
          if (!rem_any) begin
            cell_ctl.clear = 1'b1;
            state_nxt      = ST_IDLE;
          end
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      emitted_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      emitted_r <= emitted_nxt;
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      cmd_r <= in_cmd;
      key_r <= in_block;
    end
    if (load) begin
      o_hit_r      <= n_hit;
      o_slot_r     <= n_slot;
      o_wb_r       <= n_wb;
      o_wb_block_r <= n_wb_block;
      o_wb_slot_r  <= n_wb_slot;
      o_last_r     <= n_last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = o_last_r;
  assign out_tdata  = OUT_W'({o_wb_slot_r, o_wb_block_r, o_wb_r, o_slot_r, o_hit_r});

  // --------------------------------------------------------------------------
  // checks
  // --------------------------------------------------------------------------
  // the ring pointer token never splits or vanishes
  `ASSERT_CLK(a_ptr_onehot, clk, rst_n, $onehot(ptr_vec), "insert pointer not one-hot")
  // a tag is held by at most one valid entry
  `ASSERT_CLK(a_match_unique, clk, rst_n, $onehot0(match_vec), "multiple tag matches")
  // the final flush step leaves the table empty
  `ASSERT_NEXT(a_flush_empty, clk, rst_n, (state_r == ST_SCAN) && scan_go && !rem_any,
               (valid_vec == '0) && (pend_vec == '0), "table not empty after flush")

endmodule

>>> tb/tb_fifo_block_cache_tags.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_fifo_block_cache_tags
// Self-checking bench for the block cache tag and ring replacement logic.
// A directed table hits misses, hits, dirty evictions and flushes. Random
// traffic follows in four flow-control phases, with a long output hold-off
// that backs up the input. Every result transfer is checked against a
// bench-side model of the tag table.
// ----------------------------------------------------------------------------
module tb_fifo_block_cache_tags;
  import fbct_pkg::*;

  localparam int ENTRIES        = 16;
  localparam int BLK_W          = 24;
  localparam int IN_W           = ((BLK_W + 7) / 8) * 8;
  localparam int OUT_W          = ((BLK_W + 17) / 8) * 8;
  localparam int RAND_PER_PHASE = 70;
  localparam int POOL_N         = 24;   // more blocks than entries, so evictions happen
  localparam int HOLD_CYCLES    = 300;
  localparam int LIMIT_CYCLES   = 400000;

  // one result transfer, split into its fields
  typedef struct packed {
    logic             hit;
    logic [SLOT_W-1:0] slot;
    logic             wb;
    logic [BLK_W-1:0] wb_blk;
    logic [SLOT_W-1:0] wb_slot;
    logic             last;
  } cache_result_t;

  // directed stimulus row; typed == 1 means res is the expected result
  typedef struct packed {
    cmd_t          op;
    logic [BLK_W-1:0] blk;
    logic          typed;
    cache_result_t res;
  } dir_row_t;

  localparam cache_result_t NO_RES = '0;
  localparam cache_result_t MISS   = '{1'b0, 4'd0, 1'b0, 24'h0, 4'd0, 1'b1};

  // Directed part: miss after reset, flush of an empty table, mark of a
  // missing block, allocate and hit, a full ring that wraps and evicts two
  // dirty victims (block 0 and the all-ones block), then a flush.
  localparam int DIR_N = 26;
  localparam dir_row_t DIR_ROWS [DIR_N] = '{
    '{CMD_LOOKUP, 24'h000000, 1'b1, MISS},
    '{CMD_FLUSH,  24'h000000, 1'b1, MISS},
    '{CMD_MARK,   24'h123456, 1'b1, MISS},
    '{CMD_ALLOC,  24'h000000, 1'b1, MISS},
    '{CMD_ALLOC,  24'hFFFFFF, 1'b1, '{1'b0, 4'd1, 1'b0, 24'h0, 4'd0, 1'b1}},
    '{CMD_MARK,   24'hFFFFFF, 1'b1, '{1'b1, 4'd1, 1'b0, 24'h0, 4'd0, 1'b1}},
    '{CMD_ALLOC,  24'h000000, 1'b1, '{1'b1, 4'd0, 1'b0, 24'h0, 4'd0, 1'b1}},
    '{CMD_MARK,   24'h000000, 1'b1, '{1'b1, 4'd0, 1'b0, 24'h0, 4'd0, 1'b1}},
    '{CMD_ALLOC,  24'h000001, 1'b0, NO_RES},
    '{CMD_ALLOC,  24'h800000, 1'b0, NO_RES},
    '{CMD_ALLOC,  24'h7FFFFF, 1'b0, NO_RES},
    '{CMD_ALLOC,  24'hAAAAAA, 1'b0, NO_RES},
    '{CMD_ALLOC,  24'h555555, 1'b0, NO_RES},
    '{CMD_ALLOC,  24'h0F0F0F, 1'b0, NO_RES},
    '{CMD_ALLOC,  24'hF0F0F0, 1'b0, NO_RES},
    '{CMD_ALLOC,  24'h00FF00, 1'b0, NO_RES},
    '{CMD_ALLOC,  24'hFF00FF, 1'b0, NO_RES},
    '{CMD_ALLOC,  24'h333333, 1'b0, NO_RES},
    '{CMD_ALLOC,  24'hCCCCCC, 1'b0, NO_RES},
    '{CMD_ALLOC,  24'h000002, 1'b0, NO_RES},
    '{CMD_ALLOC,  24'h400000, 1'b0, NO_RES},
    '{CMD_ALLOC,  24'hFFFFFE, 1'b0, NO_RES},
    // ring wrapped: victims are the dirty entries in slots 0 and 1
    '{CMD_ALLOC,  24'h654321, 1'b1, '{1'b0, 4'd0, 1'b1, 24'h000000, 4'd0, 1'b1}},
    '{CMD_ALLOC,  24'h13579B, 1'b1, '{1'b0, 4'd1, 1'b1, 24'hFFFFFF, 4'd1, 1'b1}},
    '{CMD_MARK,   24'hFFFFFE, 1'b0, NO_RES},
    '{CMD_FLUSH,  24'h000000, 1'b0, NO_RES}
  };

  logic             clk;
  logic             rst_n;
  logic             in_tvalid;
  logic             in_tready;
  logic [IN_W-1:0]  in_tdata;   // block_num
  logic [CMD_W-1:0] in_tuser;   // cmd
  logic             out_tvalid;
  logic             out_tready;
  logic [OUT_W-1:0] out_tdata;  // hit, slot, writeback, writeback_block, writeback_slot
  logic             out_tlast;

  fifo_block_cache_tags #(
    .ENTRIES        (ENTRIES),
    .BLOCK_NUM_BITS (BLK_W)
  ) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  // bench copy of the tag table
  logic [BLK_W-1:0] tag_mirror [ENTRIES];
  logic             valid_mirror [ENTRIES];
  logic             dirty_mirror [ENTRIES];
  int               ring_ptr;

  cache_result_t    pending_results [$];
  logic [BLK_W-1:0] blk_pool [POOL_N];

  int  mismatches;
  int  cycle_count;
  int  send_idle_pct;
  int  recv_stall_pct;
  int  hold_reqs;     // bumped by the stimulus to ask for an output hold-off
  int  hold_served;   // owned by the receiver process
  int  hold_left;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Receiver: random stalls, plus a long hold-off on request. The hold-off
  // is counted here so the sender keeps offering transfers meanwhile.
  always @(posedge clk) begin
    if (hold_reqs != hold_served) begin
      hold_served = hold_reqs;
      hold_left   = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left  = hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count = cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("tb_fifo_block_cache_tags NOT OK");
      $finish;
    end
  end

  task automatic check_field(input string name, input logic [BLK_W-1:0] want,
                             input logic [BLK_W-1:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches = mismatches + 1;
    end
  endtask

  // Result side: every transfer is matched against the oldest expectation.
  always @(posedge clk) begin : result_check
    cache_result_t want;
    cache_result_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got.hit     = out_tdata[0];
      got.slot    = out_tdata[4:1];
      got.wb      = out_tdata[5];
      got.wb_blk  = out_tdata[29:6];
      got.wb_slot = out_tdata[33:30];
      got.last    = out_tlast;
      if (pending_results.size() == 0) begin
        $error("result transfer with nothing expected: tdata %0h", out_tdata);
        mismatches = mismatches + 1;
      end else begin
        want = pending_results.pop_front();
        check_field("hit", want.hit, got.hit);
        check_field("slot", want.slot, got.slot);
        check_field("writeback", want.wb, got.wb);
        check_field("writeback_block", want.wb_blk, got.wb_blk);
        check_field("writeback_slot", want.wb_slot, got.wb_slot);
        check_field("last", want.last, got.last);
        check_field("pad", '0, out_tdata[OUT_W-1:34]);
      end
    end
  end

  // Updates the table copy for one accepted command and queues its results.
  // A typed result, when given, replaces the computed one.
  task automatic cache_policy_step(input cmd_t op, input logic [BLK_W-1:0] blk,
                                   input logic typed, input cache_result_t typed_res);
    cache_result_t r;
    int hit_idx;
    int ndirty;
    int k;
    r = '0;
    r.last = 1'b1;
    if (op == CMD_FLUSH) begin
      ndirty = 0;
      for (int i = 0; i < ENTRIES; i++)
        if (valid_mirror[i] && dirty_mirror[i]) ndirty++;
      if (ndirty == 0) pending_results.push_back(r);
      k = 0;
      // one write-back per dirty entry, ascending slot order
      for (int i = 0; i < ENTRIES; i++) begin
        if (valid_mirror[i] && dirty_mirror[i]) begin
          k++;
          r = '0;
          r.wb      = 1'b1;
          r.wb_blk  = tag_mirror[i];
          r.wb_slot = SLOT_W'(i);
          r.last    = (k == ndirty);
          pending_results.push_back(r);
        end
        valid_mirror[i] = 1'b0;
        dirty_mirror[i] = 1'b0;
      end
      ring_ptr = 0;
    end else begin
      hit_idx = -1;
      for (int i = 0; i < ENTRIES; i++)
        if (hit_idx < 0 && valid_mirror[i] && tag_mirror[i] == blk) hit_idx = i;
      if (hit_idx >= 0) begin
        if (op == CMD_MARK) dirty_mirror[hit_idx] = 1'b1;
        r.hit  = 1'b1;
        r.slot = SLOT_W'(hit_idx);
      end else if (op == CMD_ALLOC) begin
        // miss: replace the entry under the ring pointer
        if (valid_mirror[ring_ptr] && dirty_mirror[ring_ptr]) begin
          r.wb      = 1'b1;
          r.wb_blk  = tag_mirror[ring_ptr];
          r.wb_slot = SLOT_W'(ring_ptr);
        end
        tag_mirror[ring_ptr]   = blk;
        valid_mirror[ring_ptr] = 1'b1;
        dirty_mirror[ring_ptr] = 1'b0;
        r.slot   = SLOT_W'(ring_ptr);
        ring_ptr = (ring_ptr + 1) % ENTRIES;
      end
      pending_results.push_back(r);
    end
    if (typed) begin
      void'(pending_results.pop_back());
      pending_results.push_back(typed_res);
    end
  endtask

  // Offers one command and waits for its transfer. Called right after a
  // rising edge; returns right after the edge that took the transfer.
  task automatic send_cmd(input cmd_t op, input logic [BLK_W-1:0] blk,
                          input logic typed = 1'b0, input cache_result_t res = '0);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= IN_W'(blk);
    in_tuser  <= op;
    do @(posedge clk); while (!in_tready);
    cache_policy_step(op, blk, typed, res);
  endtask

  task automatic random_cmd();
    int r;
    r = $urandom_range(99);
    if (r < 15)      send_cmd(CMD_LOOKUP, blk_pool[$urandom_range(POOL_N - 1)]);
    else if (r < 55) send_cmd(CMD_ALLOC, blk_pool[$urandom_range(POOL_N - 1)]);
    else if (r < 85) send_cmd(CMD_MARK, blk_pool[$urandom_range(POOL_N - 1)]);
    else if (r < 89) send_cmd(CMD_FLUSH, BLK_W'($urandom));
    else             send_cmd(cmd_t'($urandom_range(3)), BLK_W'($urandom));
  endtask

  // Sender pauses until every expected result is out, then lets a flush
  // scan worth of cycles pass.
  task automatic drain();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (ENTRIES + 4) @(posedge clk);
  endtask

  initial begin
    logic [BLK_W-1:0] base;
    rst_n          = 1'b0;
    in_tvalid      = 1'b0;
    in_tdata       = '0;
    in_tuser       = CMD_LOOKUP;
    out_tready     = 1'b0;
    mismatches     = 0;
    cycle_count    = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_reqs      = 0;
    hold_served    = 0;
    hold_left      = 0;
    ring_ptr       = 0;
    for (int i = 0; i < ENTRIES; i++) begin
      tag_mirror[i]   = '0;
      valid_mirror[i] = 1'b0;
      dirty_mirror[i] = 1'b0;
    end

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int k = 0; k < DIR_N; k++)
      send_cmd(DIR_ROWS[k].op, DIR_ROWS[k].blk, DIR_ROWS[k].typed, DIR_ROWS[k].res);
    drain();

    // random traffic; phases: free flow, idle sender, stalling receiver, both
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 77; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 77; end
        default: begin send_idle_pct = 33; recv_stall_pct = 33; end
      endcase
      // fresh block pool per phase, extremes always present
      for (int i = 0; i < POOL_N; i++) blk_pool[i] = BLK_W'($urandom);
      blk_pool[0] = '0;
      blk_pool[1] = '1;
      repeat (RAND_PER_PHASE) random_cmd();

      if (ph == 0) begin
        // Output held off while a full ring is filled, dirtied and flushed:
        // the block backs up and stalls its input. The flush gives one
        // write-back per entry.
        hold_reqs = hold_reqs + 1;
        base = BLK_W'($urandom);
        for (int i = 0; i < ENTRIES; i++) send_cmd(CMD_ALLOC, base + BLK_W'(i));
        for (int i = 0; i < ENTRIES; i++) send_cmd(CMD_MARK, base + BLK_W'(i));
        send_cmd(CMD_FLUSH, '0);
      end
      drain();
    end

    mismatches = mismatches + pending_results.size();
    if (mismatches == 0) begin
      $display("tb_fifo_block_cache_tags OK");
    end else begin
      $display("tb_fifo_block_cache_tags NOT OK");
    end
    $finish;
  end

endmodule
